// ===== rtl/tpt_pkg.sv =====
// Shared types and constants for the TLB and page-table translator.
// No dependencies; imported by every module of the block.
package tpt_pkg;

  localparam int ADDR_W     = 16;
  localparam int PAGE_W     = 8;
  localparam int OFFSET_W   = 8;
  localparam int FRAME_W    = 8;
  localparam int PAGE_COUNT = 256;
  localparam int COUNT_W    = 9;
  localparam int HIT_W      = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [HIT_W-1:0]   HIT_MAX   = {HIT_W{1'b1}};

  // Control sequence: idle, then a lookup/update state for each item
  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_LOOK = 1'b1
  } state_t;

  // TLB lookup answer for the item in the lookup cycle
  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] frame;
  } tlb_resp_t;

  // Page-table answer for the item in the lookup cycle
  typedef struct packed {
    logic               present;
    logic [FRAME_W-1:0] frame;
    logic [FRAME_W-1:0] free_frame;
    logic [COUNT_W-1:0] count_next;
  } pt_resp_t;

endpackage

// ===== rtl/tlb_page_table_translator.sv =====
// Top level of the TLB and page-table translator.
// Depends on tpt_pkg, tpt_tlb and tpt_page_table.
//
// Items are taken one at a time: start is taken when busy is low, the page-table
// RAM read launches in that cycle, and in the next (busy high) cycle the TLB
// compares, the LRU ranks and any new page-table entry are written back. The
// result shows with done for exactly one cycle after that, and the next item
// may be started in that same cycle. The receiver cannot stall: each result
// must be captured in its done cycle. The present bits sit in flip-flops that
// reset clears at once, so no clearing pass follows reset.
module tlb_page_table_translator
  import tpt_pkg::*;
#(
  parameter int TLB_ENTRIES = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [ADDR_W-1:0]   vaddr,
  output logic                done,
  output logic [ADDR_W-1:0]   paddr,
  output logic [FRAME_W-1:0]  frame_number,
  output logic                tlb_hit,
  output logic                page_fault,
  output logic [HIT_W-1:0]    hit_total,
  output logic [COUNT_W-1:0]  fault_total
);

  state_t state, state_next;
  logic   accept, look;

  logic [PAGE_W-1:0]   page;
  logic [OFFSET_W-1:0] offset;
  logic [HIT_W-1:0]    hit_counter;

  tlb_resp_t          tlb_resp;
  pt_resp_t           pt_resp;
  logic               fault;
  logic [FRAME_W-1:0] frame;

  // Next state
  always_comb begin
    case (state)
      ST_IDLE: state_next = start ? ST_LOOK : ST_IDLE;
      ST_LOOK: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        look = 1'b0;
      end
      ST_LOOK: begin
        busy = 1'b1;
        look = 1'b1;
      end
      default: begin
        busy = 1'b0;
        look = 1'b0;
      end
    endcase
  end

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the item's page and offset for the lookup cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      page   <= vaddr[ADDR_W-1:OFFSET_W];
      offset <= vaddr[OFFSET_W-1:0];
    end
  end

  tpt_tlb #(
    .TLB_ENTRIES(TLB_ENTRIES)
  ) u_tlb (
    .clk      (clk),
    .rst      (rst),
    .update   (look),
    .page     (page),
    .ins_frame(pt_resp.present ? pt_resp.frame : pt_resp.free_frame),
    .resp     (tlb_resp)
  );

  tpt_page_table u_pt (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (accept),
    .rd_page(vaddr[ADDR_W-1:OFFSET_W]),
    .page   (page),
    .alloc  (fault),
    .resp   (pt_resp)
  );

  // Pick the frame source for this item
  assign fault = look && !tlb_resp.hit && !pt_resp.present;
  always_comb begin
    if (tlb_resp.hit) begin
      frame = tlb_resp.frame;
    end else if (pt_resp.present) begin
      frame = pt_resp.frame;
    end else begin
      frame = pt_resp.free_frame;
    end
  end

  // Count hits, saturating
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_counter <= '0;
    end else if (look && tlb_resp.hit && (hit_counter != HIT_MAX)) begin
      hit_counter <= hit_counter + 1'b1;
    end
  end

  // Strobe the result in the cycle after the lookup
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= look;
    end
  end

  // Register the result item
  always_ff @(posedge clk) begin
    if (look) begin
      paddr            <= {frame, offset};
      frame_number     <= frame;
      tlb_hit          <= tlb_resp.hit;
      page_fault       <= fault;
      hit_total        <= (tlb_resp.hit && (hit_counter != HIT_MAX)) ? hit_counter + 1'b1
                                                                     : hit_counter;
      fault_total      <= pt_resp.count_next;
    end
  end

endmodule

// ===== rtl/tpt_tlb.sv =====
// Fully associative TLB: tag/frame/valid/age cells with true-LRU ranks.
// Depends on tpt_pkg; lookup is combinational, refresh or insert on update.
module tpt_tlb
  import tpt_pkg::*;
#(
  parameter int TLB_ENTRIES = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               update,
  input  logic [PAGE_W-1:0]  page,
  input  logic [FRAME_W-1:0] ins_frame,
  output tlb_resp_t          resp
);

  localparam int AW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam logic [AW-1:0] AGE_MAX = AW'(TLB_ENTRIES - 1);
  localparam logic [AW:0]   LIMIT_ALL = (AW+1)'(TLB_ENTRIES);

  logic [PAGE_W-1:0]  tag   [TLB_ENTRIES];
  logic [FRAME_W-1:0] frame [TLB_ENTRIES];
  logic [AW-1:0]      age   [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] valid;

  logic [TLB_ENTRIES-1:0] match;
  logic [AW-1:0] hit_idx, free_idx, old_idx, slot;
  logic          any_free;
  logic [AW:0]   limit;

  // Compare tags and pick hit, free and least recently used entries
  always_comb begin
    match    = '0;
    hit_idx  = '0;
    free_idx = '0;
    old_idx  = '0;
    any_free = 1'b0;
    for (int k = TLB_ENTRIES - 1; k >= 0; k--) begin
      match[k] = valid[k] && (tag[k] == page);
      if (match[k]) begin
        hit_idx = AW'(k);
      end
      if (!valid[k]) begin
        free_idx = AW'(k);
        any_free = 1'b1;
      end
      if (valid[k] && (age[k] == AGE_MAX)) begin
        old_idx = AW'(k);
      end
    end
  end

  assign resp.hit   = |match;
  assign resp.frame = frame[hit_idx];

  // Choose the slot that becomes youngest and the age limit for the rest
  always_comb begin
    if (resp.hit) begin
      slot  = hit_idx;
      limit = {1'b0, age[hit_idx]};
    end else if (any_free) begin
      slot  = free_idx;
      limit = LIMIT_ALL;
    end else begin
      slot  = old_idx;
      limit = {1'b0, AGE_MAX};
    end
  end

  // Refresh on hit, insert on miss; age the younger valid entries
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      for (int k = 0; k < TLB_ENTRIES; k++) begin
        age[k] <= '0;
      end
    end else if (update) begin
      for (int k = 0; k < TLB_ENTRIES; k++) begin
        if (AW'(k) == slot) begin
          age[k] <= '0;
          if (!resp.hit) begin
            valid[k] <= 1'b1;
            tag[k]   <= page;
            frame[k] <= ins_frame;
          end
        end else if (valid[k] && ({1'b0, age[k]} < limit) && (age[k] != AGE_MAX)) begin
          age[k] <= age[k] + 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/tpt_page_table.sv =====
// Page table: frame RAM with registered read, present bits, free-frame count.
// Depends on tpt_pkg; read issued on accept, allocation written back next cycle.
module tpt_page_table
  import tpt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [PAGE_W-1:0] rd_page,
  input  logic [PAGE_W-1:0] page,
  input  logic              alloc,
  output pt_resp_t          resp
);

  logic [FRAME_W-1:0]    frame_ram [PAGE_COUNT];
  logic [FRAME_W-1:0]    rd_data;
  logic [PAGE_COUNT-1:0] present;
  logic [COUNT_W-1:0]    next_free;

  // Read the frame entry; write it when a page is allocated
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= frame_ram[rd_page];
    end
    if (alloc) begin
      frame_ram[page] <= next_free[FRAME_W-1:0];
    end
  end

  // Mark allocated pages present and advance the free frame
  always_ff @(posedge clk) begin
    if (rst) begin
      present   <= '0;
      next_free <= '0;
    end else if (alloc) begin
      present[page] <= 1'b1;
      next_free     <= resp.count_next;
    end
  end

  assign resp.present    = present[page];
  assign resp.frame      = rd_data;
  assign resp.free_frame = next_free[FRAME_W-1:0];
  assign resp.count_next = (alloc && (next_free != COUNT_MAX)) ? next_free + 1'b1
                                                                : next_free;

endmodule

// ===== rtl/tpt_checker.sv =====
// Port-level checks for the TLB and page-table translator.
// Depends on tpt_pkg; bound to tlb_page_table_translator below.
module tpt_checker
  import tpt_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic [ADDR_W-1:0]  paddr,
  input logic [FRAME_W-1:0] frame_number,
  input logic               tlb_hit,
  input logic               page_fault
);

  // An accepted item keeps the block busy for its lookup cycle
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // Every lookup cycle is followed by exactly one result
  assert property (@(posedge clk) disable iff (rst) busy |=> (done && !busy))
    else $error("lookup not followed by a result");

  // A result never comes without a lookup before it
  assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("result without a lookup");

  // A TLB hit can never also be a page fault
  assert property (@(posedge clk) disable iff (rst) (done && tlb_hit) |-> !page_fault)
    else $error("hit reported together with a fault");

  // Physical address carries the frame in its page bits
  assert property (@(posedge clk) disable iff (rst)
    done |-> (paddr[ADDR_W-1:OFFSET_W] == frame_number))
    else $error("physical address disagrees with frame number");

endmodule

bind tlb_page_table_translator tpt_checker u_tpt_checker (.*);

// ===== sim/tb_tlb_page_table_translator.sv =====
// Self-checking testbench for tlb_page_table_translator.
// Depends on tpt_pkg and the translator RTL; holds its own TLB, LRU and page-table
// predictor and checks every done strobe against it.
module tb_tlb_page_table_translator;
  import tpt_pkg::*;

  localparam int TLB_SLOTS = 32;
  localparam int RANK_MAX  = TLB_SLOTS - 1;

  // One address lookup; drain asks the sender to wait until nothing is in flight
  typedef struct {
    logic [ADDR_W-1:0] addr;
    bit                drain;
  } lookup_t;

  // One translation result as it leaves the block
  typedef struct packed {
    logic [ADDR_W-1:0]  phys;
    logic [FRAME_W-1:0] frame;
    logic               hit;
    logic               fault;
    logic [HIT_W-1:0]   hits;
    logic [COUNT_W-1:0] faults;
  } xlate_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [ADDR_W-1:0]  vaddr = '0;
  logic               busy;
  logic               done;
  logic [ADDR_W-1:0]  paddr;
  logic [FRAME_W-1:0] frame_number;
  logic               tlb_hit;
  logic               page_fault;
  logic [HIT_W-1:0]   hit_total;
  logic [COUNT_W-1:0] fault_total;

  tlb_page_table_translator #(.TLB_ENTRIES(TLB_SLOTS)) uut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .vaddr            (vaddr),
    .done             (done),
    .paddr            (paddr),
    .frame_number     (frame_number),
    .tlb_hit          (tlb_hit),
    .page_fault       (page_fault),
    .hit_total        (hit_total),
    .fault_total      (fault_total)
  );

  always #2 clk = ~clk;

  // Predictor state
  logic [PAGE_W-1:0]  tlb_page [TLB_SLOTS];
  logic [FRAME_W-1:0] tlb_frm  [TLB_SLOTS];
  bit                 tlb_live [TLB_SLOTS];
  int                 tlb_rank [TLB_SLOTS];
  logic [FRAME_W-1:0] map_frame   [PAGE_COUNT];
  bit                 map_present [PAGE_COUNT];
  logic [COUNT_W-1:0] frames_used = '0;
  logic [HIT_W-1:0]   hits_seen = '0;

  lookup_t addr_queue[$];
  xlate_t  want_xlate[$];

  int errors = 0;
  int n_items = 0;
  int n_hits = 0;
  int n_faults = 0;
  int n_evicts = 0;
  bit hit_sat_seen = 1'b0;

  // Age every live slot other than skip whose rank is below limit
  function automatic void age_younger(int skip, int limit);
    for (int k = 0; k < TLB_SLOTS; k++) begin
      if (k != skip && tlb_live[k] && tlb_rank[k] < limit && tlb_rank[k] < RANK_MAX) begin
        tlb_rank[k]++;
      end
    end
  endfunction

  // Translate one address and advance TLB, LRU ranks, page table and counters
  function automatic xlate_t predict_translation(logic [ADDR_W-1:0] addr);
    logic [PAGE_W-1:0]  pg;
    logic [FRAME_W-1:0] frm;
    int                 slot;
    int                 limit;
    bit                 hit;
    bit                 fault;
    xlate_t             r;
    pg    = addr[ADDR_W-1:OFFSET_W];
    hit   = 1'b0;
    fault = 1'b0;
    slot  = -1;
    frm   = '0;
    for (int k = 0; k < TLB_SLOTS; k++) begin
      if (!hit && tlb_live[k] && tlb_page[k] == pg) begin
        hit  = 1'b1;
        slot = k;
      end
    end
    if (hit) begin
      frm = tlb_frm[slot];
      age_younger(slot, tlb_rank[slot]);
      tlb_rank[slot] = 0;
      if (hits_seen != HIT_MAX) hits_seen++;
      else hit_sat_seen = 1'b1;
    end else begin
      // Page fault: hand out the next free frame in order
      if (!map_present[pg]) begin
        fault = 1'b1;
        map_frame[pg]   = frames_used[FRAME_W-1:0];
        map_present[pg] = 1'b1;
        if (frames_used != COUNT_MAX) frames_used++;
      end
      frm = map_frame[pg];
      // Fill the lowest invalid slot, else replace the least recently used
      for (int k = 0; k < TLB_SLOTS; k++) begin
        if (slot < 0 && !tlb_live[k]) slot = k;
      end
      if (slot >= 0) begin
        limit = TLB_SLOTS;
      end else begin
        slot = 0;
        for (int k = 1; k < TLB_SLOTS; k++) begin
          if (tlb_rank[k] > tlb_rank[slot]) slot = k;
        end
        limit = tlb_rank[slot];
        n_evicts++;
      end
      age_younger(slot, limit);
      tlb_page[slot] = pg;
      tlb_frm[slot]  = frm;
      tlb_live[slot] = 1'b1;
      tlb_rank[slot] = 0;
    end
    r.phys   = {frm, addr[OFFSET_W-1:0]};
    r.frame  = frm;
    r.hit    = hit;
    r.fault  = fault;
    r.hits   = hits_seen;
    r.faults = frames_used;
    n_items++;
    if (hit) n_hits++;
    if (fault) n_faults++;
    return r;
  endfunction

  // Print one mismatch line (first few only) and count it
  task automatic report(string what, longint unsigned want, longint unsigned got);
    if (errors < 40) begin
      $display("[%0t] mismatch on %s: expected %0h, got %0h", $time, what, want, got);
    end
    errors++;
  endtask

  task automatic add_item(logic [ADDR_W-1:0] addr, bit drain);
    lookup_t it;
    it.addr  = addr;
    it.drain = drain;
    addr_queue.push_back(it);
  endtask

  // Monitor: check each done strobe, then predict any item taken this edge
  bit accepted = 1'b0;

  always @(posedge clk) begin
    xlate_t w;
    if (rst) begin
      accepted <= 1'b0;
    end else begin
      if (done) begin
        if (want_xlate.size() == 0) begin
          report("unexpected result", 0, paddr);
        end else begin
          w = want_xlate.pop_front();
          if (paddr !== w.phys) report("paddr", w.phys, paddr);
          if (frame_number !== w.frame) report("frame_number", w.frame, frame_number);
          if (tlb_hit !== w.hit) report("tlb_hit", w.hit, tlb_hit);
          if (page_fault !== w.fault) report("page_fault", w.fault, page_fault);
          if (hit_total !== w.hits) report("hit_total", w.hits, hit_total);
          if (fault_total !== w.faults) report("fault_total", w.faults, fault_total);
        end
      end
      if (start && !busy) begin
        want_xlate.push_back(predict_translation(vaddr));
        accepted <= 1'b1;
      end else begin
        accepted <= 1'b0;
      end
    end
  end

  // Driver: release reset, then send items in bursts with random gaps
  int rst_left = 10;
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin
    logic              nxt_start;
    logic [ADDR_W-1:0] nxt_addr;
    if (rst_left != 0) begin
      rst_left <= rst_left - 1;
      if (rst_left == 1) rst <= 1'b0;
    end else begin
      nxt_start = start;
      nxt_addr  = vaddr;
      if (accepted) begin
        void'(addr_queue.pop_front());
        if (burst_left > 0) burst_left--;
        nxt_start = 1'b0;
      end
      if (!nxt_start) begin
        if (burst_left == 0) begin
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          burst_left = $urandom_range(1, 24);
        end
        if (gap_left > 0) begin
          gap_left--;
        end else if (addr_queue.size() != 0 &&
                     !(addr_queue[0].drain && want_xlate.size() != 0)) begin
          nxt_start = 1'b1;
          nxt_addr  = addr_queue[0].addr;
        end
      end
      start <= nxt_start;
      vaddr <= nxt_addr;
    end
  end

  // Stimulus and end of run
  initial begin
    logic [PAGE_W-1:0] hot_pages [8];
    logic [PAGE_W-1:0] warm_pages [48];
    logic [PAGE_W-1:0] sweep [PAGE_COUNT];
    logic [PAGE_W-1:0] tmp;
    int                sweep_at;
    int                j;
    int                pick;

    // Directed: address extremes, hits on the same page, alternating bit patterns
    add_item(16'h0000, 1'b0);
    add_item(16'h00FF, 1'b0);
    add_item(16'hFFFF, 1'b0);
    add_item(16'hFF00, 1'b0);
    add_item(16'h8000, 1'b0);
    add_item(16'h7FFF, 1'b0);
    add_item(16'h5555, 1'b0);
    add_item(16'hAAAA, 1'b0);
    add_item(16'h0080, 1'b0);
    add_item(16'h0101, 1'b0);
    add_item(16'hFE7F, 1'b0);
    add_item(16'h55AA, 1'b0);
    add_item(16'h0001, 1'b0);
    add_item(16'hFFFE, 1'b0);

    // Random: hot set for hits, warm set larger than the TLB for LRU
    // replacement, and a shuffled sweep so every page faults once
    for (int k = 0; k < 8; k++) hot_pages[k] = PAGE_W'($urandom_range(0, 255));
    for (int k = 0; k < 48; k++) warm_pages[k] = PAGE_W'($urandom_range(0, 255));
    for (int k = 0; k < PAGE_COUNT; k++) sweep[k] = PAGE_W'(k);
    for (int k = PAGE_COUNT - 1; k > 0; k--) begin
      j        = $urandom_range(0, k);
      tmp      = sweep[k];
      sweep[k] = sweep[j];
      sweep[j] = tmp;
    end
    sweep_at = 0;
    for (int k = 0; k < 1300; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) tmp = hot_pages[$urandom_range(0, 7)];
      else if (pick < 60) tmp = warm_pages[$urandom_range(0, 47)];
      else if (pick < 80 && sweep_at < PAGE_COUNT) tmp = sweep[sweep_at++];
      else tmp = PAGE_W'($urandom_range(0, 255));
      add_item({tmp, 8'($urandom_range(0, 255))}, (k == 0) || ($urandom_range(0, 99) == 0));
    end
    while (sweep_at < PAGE_COUNT) begin
      add_item({sweep[sweep_at++], 8'($urandom_range(0, 255))}, 1'b0);
    end

    // Drain, then let trailing cycles expose any stray result
    while (addr_queue.size() != 0 || want_xlate.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Covered %0d lookups: %0d TLB hits, %0d page faults, %0d LRU replacements.",
             n_items, n_hits, n_faults, n_evicts);
    $display("Frames used %0d of %0d; hit count saturation %0s.",
             frames_used, PAGE_COUNT, hit_sat_seen ? "reached" : "not reached");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #6000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
